FILE: rtl/irrt_pkg.sv
// Shared constants, codes and types of the intra refresh request tracker.
`timescale 1ns / 1ps
`default_nettype none
package irrt_pkg;

  // Frame numbers and the non-reference tag table
  localparam int FRAME_BITS      = 48;
  localparam int NON_REF_ENTRIES = 512;
  localparam int SLOT_BITS       = $clog2(NON_REF_ENTRIES);
  localparam int TAG_BITS        = FRAME_BITS - SLOT_BITS;

  // Timeout register
  localparam int                    TIMEOUT_BITS  = 16;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(100);

  // Stream payload widths
  localparam int FUNC_BITS     = 3;
  localparam int PHASE_BITS    = 2;
  localparam int IN_DATA_BITS  = ((FRAME_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 8;

  // Event codes
  localparam logic [FUNC_BITS-1:0] FUNC_FEEDBACK   = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SKIP_QUERY = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_MARK_NREF  = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_TYPE_QUERY = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_RESTART    = 3'd4;

  // Phase codes
  localparam logic [PHASE_BITS-1:0] PH_NEED = 2'd0;
  localparam logic [PHASE_BITS-1:0] PH_WAIT = 2'd1;
  localparam logic [PHASE_BITS-1:0] PH_RECV = 2'd2;
  localparam logic [PHASE_BITS-1:0] PH_RUN  = 2'd3;

  // One entry of the tag table
  typedef struct packed {
    logic                valid;
    logic [TAG_BITS-1:0] tag;
  } nref_entry_t;

endpackage
`default_nettype wire

FILE: rtl/irrt_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module irrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/intra_refresh_request_tracker_unit.sv
// Top level of the intra refresh request tracker.
`timescale 1ns / 1ps
`default_nettype none
// Intra refresh request tracker. Every input transaction is one event (decoder
// feedback, skip query, mark non-reference, frame type query, restart) and
// yields exactly one result transaction carrying the skip answer, the intra
// answer and the phase after the event. Throughput is one event per cycle
// while the result stream does not stall. Accepting an event registers it in
// the event stage and reads or writes the non-reference tag table (one
// single-port RAM access); the phase logic then evaluates the registered event
// into the output register. The exception is the table clear: after reset and
// after every restart event, the block sweeps the 512-entry tag table one entry
// a cycle, and s_axis_tready stays low during the sweep. The timeout
// register may be written at any time the block is idle, including during
// the sweep.
module intra_refresh_request_tracker_unit
  import irrt_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Timeout register write (wait_timeout_frames)
  input  wire logic                      cfg_we_i,
  input  wire logic [TIMEOUT_BITS-1:0]   cfg_wdata_i,
  // Event stream in
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // [47:0] frame number, [48] delivered, zero above
  input  wire logic [IN_DATA_BITS-1:0]   s_axis_tdata,
  // [2:0] func
  input  wire logic [FUNC_BITS-1:0]      s_axis_tuser,
  // Result stream out
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // [0] skip_frame, [1] intra_frame, [3:2] phase_now, zero above
  output logic [OUT_DATA_BITS-1:0]       m_axis_tdata
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [TIMEOUT_BITS-1:0] timeout_q;

  // Event stage
  logic                  s1_valid_q;
  logic [FUNC_BITS-1:0]  s1_func_q;
  logic [FRAME_BITS-1:0] s1_frame_q;
  logic                  s1_deliv_q;

  // Result stage
  logic                  out_valid_q;
  logic                  out_skip_q;
  logic                  out_intra_q;
  logic [PHASE_BITS-1:0] out_phase_q;

  // Tracker state
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [FRAME_BITS-1:0] intra_num_q, intra_num_d;
  logic [FRAME_BITS-1:0] first_pred_q, first_pred_d;

  // Table clear sweep
  logic                 clr_q;
  logic [SLOT_BITS-1:0] clr_cnt_q;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic                  in_accept;
  logic                  advance;
  logic [FUNC_BITS-1:0]  in_func;
  logic [FRAME_BITS-1:0] in_frame;
  logic                  in_deliv;

  assign in_func  = s_axis_tuser;
  assign in_frame = s_axis_tdata[FRAME_BITS-1:0];
  assign in_deliv = s_axis_tdata[FRAME_BITS];

  // The event stage moves on when the result register is free or being drained
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_q && (!s1_valid_q || advance);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Tag table: marks write at acceptance, feedback reads at acceptance, the
  // clear sweep owns the port while it runs. Marks do not depend on the phase,
  // so writing them early keeps every read in event order.
  // ---------------------------------------------------------------------------
  logic                 ram_en;
  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_addr;
  nref_entry_t          ram_wdata;
  nref_entry_t          ram_rdata;

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = in_frame[SLOT_BITS-1:0];
    ram_wdata = '{valid: 1'b1, tag: in_frame[FRAME_BITS-1:SLOT_BITS]};
    if (clr_q) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = '0;
    end else if (in_accept) begin
      ram_en = (in_func == FUNC_MARK_NREF) || (in_func == FUNC_FEEDBACK);
      ram_we = (in_func == FUNC_MARK_NREF);
    end
  end

  irrt_ram #(
    .WIDTH($bits(nref_entry_t)),
    .DEPTH(NON_REF_ENTRIES)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Phase logic on the registered event
  // ---------------------------------------------------------------------------
  logic                  is_non_ref;
  logic [FRAME_BITS-1:0] frame_diff;
  logic                  timed_out;
  logic                  skip_d;
  logic                  intra_d;

  // The read data holds while the event stage stalls, since reads only happen
  // on acceptance.
  assign is_non_ref = ram_rdata.valid &&
                      (ram_rdata.tag == s1_frame_q[FRAME_BITS-1:SLOT_BITS]);

  // Difference is only meaningful when the frame is past the intra frame
  assign frame_diff = s1_frame_q - intra_num_q;
  assign timed_out  = (s1_frame_q > intra_num_q) &&
                      (frame_diff > {{(FRAME_BITS-TIMEOUT_BITS){1'b0}}, timeout_q});

  always_comb begin
    phase_d      = phase_q;
    intra_num_d  = intra_num_q;
    first_pred_d = first_pred_q;
    skip_d       = 1'b0;
    intra_d      = 1'b0;
    case (s1_func_q)
      FUNC_FEEDBACK: begin
        if (phase_q == PH_WAIT) begin
          if (s1_frame_q == intra_num_q) begin
            phase_d = s1_deliv_q ? PH_RECV : PH_NEED;
          end
        end else if (phase_q == PH_RUN) begin
          // Lost reference frame after the intra cycle: ask for a new intra
          if (!s1_deliv_q && (s1_frame_q >= first_pred_q) && !is_non_ref) begin
            phase_d = PH_NEED;
          end
        end
      end
      FUNC_SKIP_QUERY: begin
        if (phase_q == PH_WAIT) begin
          if (timed_out) begin
            phase_d = PH_NEED;
          end else begin
            skip_d = 1'b1;
          end
        end
      end
      FUNC_TYPE_QUERY: begin
        if (phase_q == PH_NEED) begin
          intra_num_d = s1_frame_q;
          phase_d     = PH_WAIT;
          intra_d     = 1'b1;
        end else if (phase_q == PH_RECV) begin
          first_pred_d = s1_frame_q;
          phase_d      = PH_RUN;
        end
      end
      FUNC_RESTART: begin
        phase_d = PH_NEED;
      end
      default: begin
        // Marks were already written to the table; unused codes do nothing
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TIMEOUT_RESET;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_NEED;
      intra_num_q  <= '0;
      first_pred_q <= '0;
      clr_q        <= 1'b1;
      clr_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end

      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q  <= 1'b1;
        phase_q      <= phase_d;
        intra_num_q  <= intra_num_d;
        first_pred_q <= first_pred_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // Sweep the table after reset and after each accepted restart
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == SLOT_BITS'(NON_REF_ENTRIES - 1)) begin
          clr_q <= 1'b0;
        end
      end else if (in_accept && (in_func == FUNC_RESTART)) begin
        clr_q     <= 1'b1;
        clr_cnt_q <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q  <= in_func;
      s1_frame_q <= in_frame;
      s1_deliv_q <= in_deliv;
    end
    if (advance) begin
      out_skip_q  <= skip_d;
      out_intra_q <= intra_d;
      out_phase_q <= phase_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_BITS-PHASE_BITS-2){1'b0}},
                          out_phase_q, out_intra_q, out_skip_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // No event enters while the table is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready)
    else $error("event accepted during table clear");

  // An accepted restart starts the clear sweep
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_func == FUNC_RESTART)) |=> clr_q)
    else $error("restart did not start table clear");

  // Intra query in need phase moves to waiting
  a_intra_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (s1_func_q == FUNC_TYPE_QUERY) && (phase_q == PH_NEED))
    |=> (phase_q == PH_WAIT))
    else $error("intra query did not enter waiting phase");

  // An intra answer always reports the waiting phase
  a_intra_result_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_intra_q) |-> (out_phase_q == PH_WAIT))
    else $error("intra answer with wrong phase");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_intra_refresh_request_tracker_unit.sv
// Self-checking testbench of the intra refresh request tracker.
`timescale 1ns / 1ps
`default_nettype none
module tb_intra_refresh_request_tracker_unit;
  import irrt_pkg::*;

  // Event codes the block must ignore
  localparam logic [FUNC_BITS-1:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [FUNC_BITS-1:0] FUNC_SPARE_7 = 3'd7;

  localparam logic [FRAME_BITS-1:0] FRAME_MAX  = {FRAME_BITS{1'b1}};
  localparam logic [FRAME_BITS-1:0] FRAME_HIGH = FRAME_MAX - FRAME_BITS'(48'h10_0000);

  localparam int  IDLE_PCT         = 29;
  localparam int  SETTINGS_COUNT   = 5;
  localparam int  EVENTS_PER_SETTING = 85;
  localparam int  TAIL_CYCLES      = 8;
  localparam int  RECENT_MARKS     = 8;
  localparam bit  TYPED            = 1'b1;
  localparam bit  PREDICTED        = 1'b0;

  typedef struct packed {
    logic [FUNC_BITS-1:0]  func;
    logic [FRAME_BITS-1:0] frame;
    logic                  delivered;
  } irrt_event_t;

  typedef struct packed {
    logic                  skip_frame;
    logic                  intra_frame;
    logic [PHASE_BITS-1:0] phase_now;
  } irrt_answer_t;

  // One directed stimulus row; the answer columns count only when typed is set
  typedef struct packed {
    logic [FUNC_BITS-1:0]  func;
    logic [FRAME_BITS-1:0] frame;
    logic                  delivered;
    logic                  typed;
    logic                  skip_frame;
    logic                  intra_frame;
    logic [PHASE_BITS-1:0] phase_now;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 26;

  // Runs on the reset timeout of 100 frames
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // feedback, skip query and spare codes with nothing started: no effect
    '{FUNC_FEEDBACK,   48'd0,            1'b1, TYPED,     1'b0, 1'b0, PH_NEED},
    '{FUNC_SKIP_QUERY, FRAME_MAX,        1'b1, TYPED,     1'b0, 1'b0, PH_NEED},
    '{FUNC_SPARE_5,    FRAME_MAX,        1'b1, TYPED,     1'b0, 1'b0, PH_NEED},
    '{FUNC_SPARE_7,    48'h5555_5555_5555, 1'b0, TYPED,   1'b0, 1'b0, PH_NEED},
    // mark frame 7 non-reference while no intra is out
    '{FUNC_MARK_NREF,  48'd7,            1'b0, TYPED,     1'b0, 1'b0, PH_NEED},
    // start an intra frame, then probe the timeout boundary
    '{FUNC_TYPE_QUERY, 48'd1000,         1'b0, TYPED,     1'b0, 1'b1, PH_WAIT},
    '{FUNC_SKIP_QUERY, 48'd1100,         1'b1, PREDICTED, 1'b0, 1'b0, PH_WAIT},
    '{FUNC_SKIP_QUERY, 48'd500,          1'b0, PREDICTED, 1'b0, 1'b0, PH_WAIT},
    '{FUNC_FEEDBACK,   48'd999,          1'b1, PREDICTED, 1'b0, 1'b0, PH_WAIT},
    '{FUNC_SKIP_QUERY, 48'd1101,         1'b0, TYPED,     1'b0, 1'b0, PH_NEED},
    // intra frame reported lost
    '{FUNC_TYPE_QUERY, 48'd2000,         1'b1, TYPED,     1'b0, 1'b1, PH_WAIT},
    '{FUNC_FEEDBACK,   48'd2000,         1'b0, TYPED,     1'b0, 1'b0, PH_NEED},
    // intra frame delivered, then first predicted frame
    '{FUNC_TYPE_QUERY, 48'd0,            1'b0, TYPED,     1'b0, 1'b1, PH_WAIT},
    '{FUNC_FEEDBACK,   48'd0,            1'b1, TYPED,     1'b0, 1'b0, PH_RECV},
    '{FUNC_SKIP_QUERY, 48'd300,          1'b1, PREDICTED, 1'b0, 1'b0, PH_RECV},
    '{FUNC_TYPE_QUERY, 48'd5,            1'b1, TYPED,     1'b0, 1'b0, PH_RUN},
    // loss before the first predicted frame, loss of a non-reference frame,
    // then loss of a frame sharing the slot under another tag
    '{FUNC_FEEDBACK,   48'd4,            1'b0, PREDICTED, 1'b0, 1'b0, PH_RUN},
    '{FUNC_FEEDBACK,   48'd7,            1'b0, TYPED,     1'b0, 1'b0, PH_RUN},
    '{FUNC_FEEDBACK,   48'd519,          1'b0, TYPED,     1'b0, 1'b0, PH_NEED},
    // the same cycle at the top frame number
    '{FUNC_TYPE_QUERY, FRAME_MAX,        1'b0, TYPED,     1'b0, 1'b1, PH_WAIT},
    '{FUNC_SKIP_QUERY, 48'd0,            1'b0, TYPED,     1'b1, 1'b0, PH_WAIT},
    '{FUNC_FEEDBACK,   FRAME_MAX,        1'b1, TYPED,     1'b0, 1'b0, PH_RECV},
    '{FUNC_TYPE_QUERY, FRAME_MAX,        1'b1, TYPED,     1'b0, 1'b0, PH_RUN},
    '{FUNC_MARK_NREF,  FRAME_MAX,        1'b1, TYPED,     1'b0, 1'b0, PH_RUN},
    '{FUNC_FEEDBACK,   FRAME_MAX,        1'b0, TYPED,     1'b0, 1'b0, PH_RUN},
    '{FUNC_RESTART,    48'd0,            1'b0, TYPED,     1'b0, 1'b0, PH_NEED}
  };

  // Block ports
  logic                     clk_i;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [TIMEOUT_BITS-1:0]  cfg_wdata_i   = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic [FUNC_BITS-1:0]     s_axis_tuser  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  // Tracker state as the testbench sees it
  logic [TIMEOUT_BITS-1:0]    trk_timeout    = TIMEOUT_RESET;
  logic [PHASE_BITS-1:0]      trk_phase      = PH_NEED;
  logic [FRAME_BITS-1:0]      trk_intra_no   = '0;
  logic [FRAME_BITS-1:0]      trk_first_p_no = '0;
  logic [FRAME_BITS-1:0]      nref_tag [NON_REF_ENTRIES];
  logic [NON_REF_ENTRIES-1:0] nref_valid     = '0;

  irrt_answer_t          pending_answers [$];
  logic [FRAME_BITS-1:0] cur_frame = '0;
  logic [FRAME_BITS-1:0] recent_marks [$];
  bit                    no_idle = 1'b0;

  int fail_count   = 0;
  int n_events     = 0;
  int n_results    = 0;
  int n_restarts   = 0;
  int n_intra      = 0;
  int n_timeouts   = 0;
  int n_losses     = 0;
  int n_nref_saves = 0;

  intra_refresh_request_tracker_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [47:0] frame number, [48] delivered
    .s_axis_tuser  (s_axis_tuser),   // [2:0] func
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [0] skip, [1] intra, [3:2] phase
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Apply one event to the tracker state and return the answer it gives
  function automatic irrt_answer_t advance_tracker(irrt_event_t ev);
    irrt_answer_t         ans;
    logic [SLOT_BITS-1:0] slot;
    logic                 nref_hit;
    ans      = '0;
    slot     = ev.frame[SLOT_BITS-1:0];
    nref_hit = nref_valid[slot] && nref_tag[slot] == ev.frame;
    case (ev.func)
      FUNC_FEEDBACK: begin
        if (trk_phase == PH_WAIT) begin
          if (ev.frame == trk_intra_no) trk_phase = ev.delivered ? PH_RECV : PH_NEED;
        end else if (trk_phase == PH_RUN && !ev.delivered && ev.frame >= trk_first_p_no) begin
          if (nref_hit) begin
            n_nref_saves++;
          end else begin
            trk_phase = PH_NEED;
            n_losses++;
          end
        end
      end
      FUNC_SKIP_QUERY: begin
        if (trk_phase == PH_WAIT) begin
          if (ev.frame > trk_intra_no &&
              ev.frame - trk_intra_no > FRAME_BITS'(trk_timeout)) begin
            trk_phase = PH_NEED;
            n_timeouts++;
          end else begin
            ans.skip_frame = 1'b1;
          end
        end
      end
      FUNC_MARK_NREF: begin
        nref_tag[slot]   = ev.frame;
        nref_valid[slot] = 1'b1;
      end
      FUNC_TYPE_QUERY: begin
        if (trk_phase == PH_NEED) begin
          trk_intra_no    = ev.frame;
          trk_phase       = PH_WAIT;
          ans.intra_frame = 1'b1;
          n_intra++;
        end else if (trk_phase == PH_RECV) begin
          trk_first_p_no = ev.frame;
          trk_phase      = PH_RUN;
        end
      end
      FUNC_RESTART: begin
        trk_phase  = PH_NEED;
        nref_valid = '0;
        n_restarts++;
      end
      default: ;
    endcase
    ans.phase_now = trk_phase;
    return ans;
  endfunction

  function automatic logic [FRAME_BITS-1:0] frame_plus(logic [FRAME_BITS-1:0] base,
                                                       longint unsigned offset);
    logic [FRAME_BITS:0] sum;
    sum = {1'b0, base} + (FRAME_BITS + 1)'(offset);
    return sum[FRAME_BITS] ? FRAME_MAX : sum[FRAME_BITS-1:0];
  endfunction

  function automatic logic [FRAME_BITS-1:0] frame_minus(logic [FRAME_BITS-1:0] base,
                                                        longint unsigned offset);
    return (base > FRAME_BITS'(offset)) ? base - FRAME_BITS'(offset) : '0;
  endfunction

  function automatic logic [FRAME_BITS-1:0] rand_frame();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FRAME_BITS-1:0];
  endfunction

  function automatic logic [FRAME_BITS-1:0] pick_marked_frame();
    if (recent_marks.size() == 0) return frame_plus(trk_first_p_no, $urandom_range(0, 63));
    return recent_marks[$urandom_range(0, recent_marks.size() - 1)];
  endfunction

  // Build the next random event, steering it by the phase the tracker is in
  function automatic irrt_event_t pick_event();
    irrt_event_t     ev;
    int unsigned     r;
    longint unsigned off;
    cur_frame    = frame_plus(cur_frame, $urandom_range(0, 2));
    ev.func      = FUNC_TYPE_QUERY;
    ev.frame     = cur_frame;
    ev.delivered = ($urandom_range(0, 1) != 0);
    r = $urandom_range(0, 99);
    if (r < 15) begin
      // noise: any code, any frame
      ev.func  = FUNC_BITS'($urandom_range(0, 7));
      ev.frame = $urandom_range(0, 1) ? rand_frame() : frame_plus(cur_frame, $urandom_range(0, 600));
      return ev;
    end
    r = $urandom_range(0, 99);
    case (trk_phase)
      PH_NEED: begin
        if (r >= 85) ev.func = $urandom_range(0, 1) ? FUNC_SKIP_QUERY : FUNC_FEEDBACK;
      end
      PH_WAIT: begin
        if (r < 50) begin
          ev.func = FUNC_SKIP_QUERY;
          case ($urandom_range(0, 5))
            0:       off = 0;
            1:       off = trk_timeout - 1;
            2:       off = trk_timeout;
            3:       off = trk_timeout + 1;
            4:       off = $urandom_range(0, trk_timeout + 2);
            default: off = $urandom_range(1, 4);
          endcase
          ev.frame = ($urandom_range(0, 5) == 0) ? frame_minus(trk_intra_no, $urandom_range(1, 50))
                                                 : frame_plus(trk_intra_no, off);
        end else if (r < 72) begin
          ev.func      = FUNC_FEEDBACK;
          ev.frame     = trk_intra_no;
          ev.delivered = $urandom_range(0, 99) < 75;
        end else if (r < 82) begin
          ev.func  = FUNC_FEEDBACK;
          ev.frame = frame_plus(trk_intra_no, $urandom_range(1, 3));
        end else if (r >= 92) begin
          ev.func = FUNC_MARK_NREF;
        end
      end
      PH_RECV: begin
        if (r >= 80) ev.func = $urandom_range(0, 1) ? FUNC_SKIP_QUERY : FUNC_FEEDBACK;
      end
      default: begin
        if (r < 25) begin
          ev.func  = FUNC_MARK_NREF;
          ev.frame = frame_plus(trk_first_p_no, $urandom_range(0, 63) +
                                ($urandom_range(0, 3) == 0 ? 512 * $urandom_range(1, 3) : 0));
          recent_marks.push_back(ev.frame);
          if (recent_marks.size() > RECENT_MARKS) void'(recent_marks.pop_front());
        end else if (r < 60) begin
          ev.func      = FUNC_FEEDBACK;
          ev.frame     = $urandom_range(0, 1) ? pick_marked_frame()
                                              : frame_plus(trk_first_p_no, $urandom_range(0, 63));
          ev.delivered = $urandom_range(0, 99) < 80;
        end else if (r < 68) begin
          ev.func      = FUNC_FEEDBACK;
          ev.frame     = frame_minus(trk_first_p_no, $urandom_range(1, 4));
          ev.delivered = 1'b0;
        end else if (r < 78) begin
          ev.func = FUNC_SKIP_QUERY;
        end else if (r < 88) begin
          ev.func = FUNC_TYPE_QUERY;
        end else if (r < 91) begin
          ev.func = FUNC_RESTART;
        end else begin
          // same slot as a marked frame, different tag
          ev.func      = FUNC_FEEDBACK;
          ev.frame     = frame_plus(pick_marked_frame(), NON_REF_ENTRIES);
          ev.delivered = 1'b0;
        end
      end
    endcase
    return ev;
  endfunction

  // Offer one event, hold it until accepted, then record what it should yield
  task automatic send_event(irrt_event_t ev, logic typed, irrt_answer_t typed_answer);
    irrt_answer_t predicted;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.func;
    s_axis_tdata  <= IN_DATA_BITS'({ev.delivered, ev.frame});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = advance_tracker(ev);
    pending_answers.push_back(typed ? typed_answer : predicted);
    n_events++;
  endtask

  // Drop valid and hold until every outstanding answer has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [TIMEOUT_BITS-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    trk_timeout  = value;
  endtask

  // Result sink: random back-pressure, except during the no-idle stretch
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin : result_check
    irrt_answer_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      n_results++;
      if (pending_answers.size() == 0) begin
        $error("result transaction with no event pending, tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata[0] !== want.skip_frame) begin
          $error("skip_frame: expected %0d, got %0d", want.skip_frame, m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tdata[1] !== want.intra_frame) begin
          $error("intra_frame: expected %0d, got %0d", want.intra_frame, m_axis_tdata[1]);
          fail_count++;
        end
        if (m_axis_tdata[3:2] !== want.phase_now) begin
          $error("phase_now: expected %0d, got %0d", want.phase_now, m_axis_tdata[3:2]);
          fail_count++;
        end
        if (m_axis_tdata[OUT_DATA_BITS-1:4] !== '0) begin
          $error("tdata padding: expected 0, got %h", m_axis_tdata[OUT_DATA_BITS-1:4]);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    irrt_event_t             ev;
    irrt_answer_t            typed_answer;
    logic [TIMEOUT_BITS-1:0] timeout_value;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed rows on the reset timeout
    foreach (directed_rows[i]) begin
      ev.func                  = directed_rows[i].func;
      ev.frame                 = directed_rows[i].frame;
      ev.delivered             = directed_rows[i].delivered;
      typed_answer.skip_frame  = directed_rows[i].skip_frame;
      typed_answer.intra_frame = directed_rows[i].intra_frame;
      typed_answer.phase_now   = directed_rows[i].phase_now;
      send_event(ev, directed_rows[i].typed, typed_answer);
    end

    // Random events under several timeouts, extremes first; one setting runs
    // with both sides streaming at full rate
    for (int s = 0; s < SETTINGS_COUNT; s++) begin
      case (s)
        0:       timeout_value = TIMEOUT_BITS'(1);
        1:       timeout_value = {TIMEOUT_BITS{1'b1}};
        2:       timeout_value = TIMEOUT_BITS'($urandom_range(2, 300));
        3:       timeout_value = TIMEOUT_RESET;
        default: timeout_value = TIMEOUT_BITS'($urandom_range(1, 65535));
      endcase
      write_timeout(timeout_value);
      no_idle   = (s == 2);
      cur_frame = ($urandom_range(0, 1) != 0) ? rand_frame()
                                               : FRAME_BITS'($urandom_range(0, 5000));
      if (cur_frame > FRAME_HIGH) cur_frame = FRAME_HIGH;
      recent_marks.delete();
      for (int k = 0; k < EVENTS_PER_SETTING; k++) begin
        if ($urandom_range(0, 99) < 2) wait_drained();
        send_event(pick_event(), PREDICTED, '0);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d events and %0d results: %0d intra starts, %0d wait timeouts,",
             n_events, n_results, n_intra, n_timeouts);
    $display("  %0d reference losses, %0d non-reference losses ignored, %0d restarts",
             n_losses, n_nref_saves, n_restarts);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run, even if every event were a
  // restart with its full table sweep
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/irrt_pkg.sv
rtl/irrt_ram.sv
rtl/intra_refresh_request_tracker_unit.sv
tb/tb_intra_refresh_request_tracker_unit.sv
